[src/photon_momentum_from_cluster_unit_macros.svh]
// ---------------------------------------------------------------------------
// Photon momentum unit assertion macros
// Shared concurrent assertion forms used by the top-level RTL module.
// ---------------------------------------------------------------------------
`ifndef PHOTON_MOMENTUM_FROM_CLUSTER_UNIT_MACROS_SVH
`define PHOTON_MOMENTUM_FROM_CLUSTER_UNIT_MACROS_SVH

// Assert an implication on the rising clock edge, disabled while reset is low.
`define PMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert a next-cycle implication on the rising clock edge.
`define PMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pmc_pkg.sv]
// ---------------------------------------------------------------------------
// Photon momentum package
// Widths, constants and the per-stage item record shared by all modules.
// ---------------------------------------------------------------------------
package pmc_pkg;
	localparam int PosW    = 24;
	localparam int EnW     = 17;
	localparam int FrontW  = 23;
	localparam int SlopeW  = 24;
	localparam int DzW     = 26;
	localparam int QW      = 48;
	localparam int RootW   = 24;
	localparam int DivNumW = 47;
	localparam int DivDenW = 26;

	localparam logic [12:0] ShowerOffset = 13'd4224;
	localparam logic [1:0]  RegFront     = 2'd0;
	// Reciprocal of five scaled by 2^23; the factor eight of forty is a shift.
	localparam logic [20:0] DepthRecip   = 21'd1677722;

	typedef struct packed {
		logic                    fault;
		logic [EnW-1:0]          energy;
		logic signed [SlopeW-1:0] sx;
		logic signed [SlopeW-1:0] sy;
	} pmc_slope_t;

	typedef struct packed {
		logic signed [17:0] mom_x;
		logic signed [17:0] mom_y;
		logic [16:0]        mom_z;
		logic [16:0]        mom_e;
		logic               div_fault;
	} pmc_result_t;
endpackage

[src/photon_momentum_from_cluster_unit.sv]
// ---------------------------------------------------------------------------
// Photon momentum from cluster unit
// Four-momentum of a neutral particle from one calorimeter cluster and the
// event vertex, in fixed point.
// ---------------------------------------------------------------------------
// Channel    Dir  Contents
// s_axis     in   tdata: cluster_x, cluster_y, cluster_energy, vertex_x,
//                 vertex_y, vertex_z
// m_axis     out  tdata: mom_x, mom_y, mom_z, mom_e, div_fault
// apb        in   calorimeter_front_z at address 0
//
// One item is accepted every cycle except during a stall; the path runs through the
// 47-stage slope dividers, the 24-stage square root, the 47-stage momentum
// dividers and four single stage registers including the output register.
// All pipeline stages advance together whenever the output register is
// empty or being read; a stall freezes every stage.
// Reset clears the valid bits and the front position register.
module photon_momentum_from_cluster_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cluster_x, cluster_y, cluster_energy, vertex_x, vertex_y, vertex_z
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// mom_x, mom_y, mom_z, mom_e, div_fault
	output logic [79:0]  m_axis_tdata
);
	import pmc_pkg::*;
	`include "photon_momentum_from_cluster_unit_macros.svh"

	localparam int SlopeLat = DivNumW;
	localparam int Lat = 1 + SlopeLat + 1 + RootW + 1 + DivNumW;

	logic [FrontW-1:0] front_q;
	logic              en;
	logic [Lat-1:0]    vld_q;
	logic              out_vld_q;
	pmc_result_t       out_q;

	assign pready = 1'b1;
	assign prdata = {9'b0, front_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
		end else if (psel && penable && pwrite && paddr == RegFront) begin
			front_q <= pwdata[FrontW-1:0];
		end
	end

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: differences and shower depth.
	logic signed [PosW-1:0] cx, cy, vx, vy, vz;
	logic [EnW-1:0]         e_in;
	logic [22:0]            depth_num;
	logic [40:0]            depth_prod;
	logic [17:0]            depth;
	assign cx   = s_axis_tdata[23:0];
	assign cy   = s_axis_tdata[47:24];
	assign e_in = s_axis_tdata[64:48];
	assign vx   = s_axis_tdata[88:65];
	assign vy   = s_axis_tdata[112:89];
	assign vz   = s_axis_tdata[136:113];
	assign depth_num  = 23'(e_in) * 23'd43 + 23'd20;
	assign depth_prod = 41'(depth_num[22:3]) * 41'(DepthRecip);
	assign depth      = depth_prod[40:23];

	logic signed [DzW-1:0]  dzp_s1;
	logic [17:0]            depth_s1;
	logic signed [PosW:0]   dx_s1, dy_s1;
	logic [EnW-1:0]         e_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dzp_s1   <= DzW'(vz) - DzW'({1'b0, front_q}) - DzW'({1'b0, ShowerOffset});
			depth_s1 <= depth;
			dx_s1    <= (PosW+1)'(vx) - (PosW+1)'(cx);
			dy_s1    <= (PosW+1)'(vy) - (PosW+1)'(cy);
			e_s1     <= e_in;
		end
	end

	// Slope division on magnitudes.
	logic signed [DzW-1:0] dz;
	logic [DzW-1:0]        adz;
	logic [DivNumW-1:0]    nx, ny;
	logic                  sgx, sgy;
	assign dz  = dzp_s1 - DzW'(depth_s1);
	assign adz = dz[DzW-1] ? DzW'(-dz) : dz;
	assign nx  = {(DivNumW-20)'(dx_s1[PosW] ? -dx_s1 : dx_s1), 20'b0};
	assign ny  = {(DivNumW-20)'(dy_s1[PosW] ? -dy_s1 : dy_s1), 20'b0};
	assign sgx = dx_s1[PosW] ^ dz[DzW-1];
	assign sgy = dy_s1[PosW] ^ dz[DzW-1];

	localparam int TagW = EnW + 3;
	logic [DivNumW-1:0] qx, qy;
	logic [TagW-1:0]    slope_tag_q [DivNumW];
	logic [TagW-1:0]    tag_x;

	always_ff @(posedge clk) begin
		if (en) begin
			slope_tag_q[0] <= {dz == '0, sgx, sgy, e_s1};
			for (int i = 1; i < DivNumW; i++) slope_tag_q[i] <= slope_tag_q[i-1];
		end
	end
	assign tag_x = slope_tag_q[DivNumW-1];

	pmc_div u_divx (.clk, .en, .num(nx), .den(adz), .quo(qx));
	pmc_div u_divy (.clk, .en, .num(ny), .den(adz), .quo(qy));

	function automatic logic signed [SlopeW-1:0] sat(input logic [DivNumW-1:0] m,
		input logic neg);
		logic signed [SlopeW-1:0] r;
		if (neg) r = (m > DivNumW'(24'h800000)) ? 24'sh800000 : SlopeW'(-m);
		else     r = (m > DivNumW'(24'h7fffff)) ? 24'sh7fffff : SlopeW'(m);
		return r;
	endfunction

	pmc_slope_t sl_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sl_s2.fault  <= tag_x[TagW-1];
			sl_s2.energy <= tag_x[EnW-1:0];
			sl_s2.sx     <= sat(qx, tag_x[EnW+1]);
			sl_s2.sy     <= sat(qy, tag_x[EnW]);
		end
	end

	logic [QW-1:0] q_in;
	assign q_in = QW'(64'h100_0000_0000) + QW'(sl_s2.sx * sl_s2.sx)
		+ QW'(sl_s2.sy * sl_s2.sy);

	logic [RootW-1:0]   root;
	pmc_slope_t         sl_r;
	pmc_sqrt u_sqrt (
		.clk, .en, .q(q_in), .tag(sl_s2), .root(root), .tag_out(sl_r)
	);

	// Numerators for the momentum division.
	logic [RootW-1:0]     root_s3;
	pmc_slope_t           sl_s3;
	logic [40:0]          ex_s3, ey_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			root_s3 <= root;
			sl_s3   <= sl_r;
			ex_s3   <= 41'(sl_r.energy) * 41'(sl_r.sx[SlopeW-1] ? -sl_r.sx : sl_r.sx);
			ey_s3   <= 41'(sl_r.energy) * 41'(sl_r.sy[SlopeW-1] ? -sl_r.sy : sl_r.sy);
		end
	end

	localparam int MTagW = EnW + 3;
	logic [DivNumW-1:0] pxq, pyq, pzq;
	logic [MTagW-1:0]   mom_tag_q [DivNumW];
	logic [MTagW-1:0]   mtag;

	always_ff @(posedge clk) begin
		if (en) begin
			mom_tag_q[0] <= {sl_s3.fault, sl_s3.sx[SlopeW-1], sl_s3.sy[SlopeW-1],
				sl_s3.energy};
			for (int i = 1; i < DivNumW; i++) mom_tag_q[i] <= mom_tag_q[i-1];
		end
	end
	assign mtag = mom_tag_q[DivNumW-1];

	pmc_div u_divz (
		.clk, .en, .num({10'b0, sl_s3.energy, 20'b0}), .den({2'b0, root_s3}),
		.quo(pzq)
	);
	pmc_div u_divpx (
		.clk, .en, .num({6'b0, ex_s3}), .den({2'b0, root_s3}), .quo(pxq)
	);
	pmc_div u_divpy (
		.clk, .en, .num({6'b0, ey_s3}), .den({2'b0, root_s3}), .quo(pyq)
	);

	pmc_result_t res;
	always_comb begin
		res.mom_e     = mtag[EnW-1:0];
		res.div_fault = mtag[EnW+2];
		res.mom_z     = mtag[EnW+2] ? '0 : pzq[16:0];
		res.mom_x     = mtag[EnW+2] ? '0 : (mtag[EnW+1] ? -18'(pxq) : 18'(pxq));
		res.mom_y     = mtag[EnW+2] ? '0 : (mtag[EnW] ? -18'(pyq) : 18'(pyq));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[Lat-2:0], s_axis_tvalid};
			out_vld_q <= vld_q[Lat-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= res;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {9'b0, out_q.div_fault, out_q.mom_e, out_q.mom_z,
		out_q.mom_y, out_q.mom_x};

	`PMC_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_vld_q, s_axis_tready,
		"input blocked while output register empty")
	`PMC_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, out_vld_q && !m_axis_tready,
		out_vld_q && $stable(m_axis_tdata), "result lost during stall")
	`PMC_ASSERT_IMPL(a_fault_zero, clk, arst_n, out_vld_q && out_q.div_fault,
		out_q.mom_x == '0 && out_q.mom_y == '0 && out_q.mom_z == '0,
		"fault with nonzero momentum")
endmodule

[src/pmc_div.sv]
// ---------------------------------------------------------------------------
// Photon momentum restoring divider
// Unsigned pipelined divider, one quotient bit per stage; the stall enable
// freezes every stage together.
// ---------------------------------------------------------------------------
module pmc_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [pmc_pkg::DivNumW-1:0] num,
	input  logic [pmc_pkg::DivDenW-1:0] den,
	output logic [pmc_pkg::DivNumW-1:0] quo
);
	import pmc_pkg::*;

	logic [DivDenW:0]   rem_s [DivNumW+1];
	logic [DivNumW-1:0] n_s   [DivNumW+1];
	logic [DivDenW-1:0] d_s   [DivNumW+1];

	always_comb begin
		rem_s[0] = '0;
		n_s[0]   = num;
		d_s[0]   = den;
	end

	for (genvar i = 0; i < DivNumW; i++) begin : g_st
		logic [DivDenW+1:0] sh;
		logic [DivDenW+1:0] df;
		always_comb begin
			sh = {rem_s[i], n_s[i][DivNumW-1]};
			df = sh - {2'b0, d_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= df[DivDenW+1] ? sh[DivDenW:0] : df[DivDenW:0];
				n_s[i+1]   <= {n_s[i][DivNumW-2:0], ~df[DivDenW+1]};
				d_s[i+1]   <= d_s[i];
			end
		end
	end

	assign quo = n_s[DivNumW];
endmodule

[src/pmc_sqrt.sv]
// ---------------------------------------------------------------------------
// Photon momentum square root
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module pmc_sqrt (
	input  logic                 clk,
	input  logic                 en,
	input  logic [47:0]          q,
	input  pmc_pkg::pmc_slope_t  tag,
	output logic [23:0]          root,
	output pmc_pkg::pmc_slope_t  tag_out
);
	import pmc_pkg::*;

	logic [49:0]   r_s [25];
	logic [23:0]   v_s [25];
	logic [47:0]   q_s [25];
	pmc_slope_t    t_s [25];

	always_comb begin
		r_s[0] = '0;
		v_s[0] = '0;
		q_s[0] = q;
		t_s[0] = tag;
	end

	for (genvar i = 0; i < 24; i++) begin : g_st
		logic [49:0] sh;
		logic [49:0] tr;
		always_comb begin
			sh = {r_s[i][47:0], q_s[i][47:46]};
			tr = {24'b0, v_s[i], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1] <= (sh >= tr) ? sh - tr : sh;
				v_s[i+1] <= {v_s[i][22:0], sh >= tr};
				q_s[i+1] <= {q_s[i][45:0], 2'b00};
				t_s[i+1] <= t_s[i];
			end
		end
	end

	assign root    = v_s[24];
	assign tag_out = t_s[24];
endmodule

[bench/tb_photon_momentum_from_cluster_unit.sv]
// ---------------------------------------------------------------------------
// Photon momentum unit testbench
// Drives clusters and vertices through the stream input and compares every
// four-momentum on the stream output against a fixed-point predictor,
// across several calorimeter front positions, with random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_photon_momentum_from_cluster_unit;
	import pmc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [17:0] mx;
		logic signed [17:0] my;
		logic [16:0]        mz;
		logic [16:0]        me;
		logic               fault;
	} momentum_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [1:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// cluster_x, cluster_y, cluster_energy, vertex_x, vertex_y, vertex_z
	logic [143:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// mom_x, mom_y, mom_z, mom_e, div_fault
	logic [79:0]  m_axis_tdata;

	momentum_t    pending_momenta[$];
	logic [22:0]  front_z = '0;
	int           mismatches = 0;
	int           burst_left = 0;
	bit           stall_free = 0;

	photon_momentum_from_cluster_unit uut (.*);

	always #2 clk = ~clk;

	function automatic longint isqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint slope(longint num, longint den);
		longint s = (num * 64'sd1048576) / den;
		if (s > 64'sd8388607) s = 64'sd8388607;
		if (s < -64'sd8388608) s = -64'sd8388608;
		return s;
	endfunction

	function automatic momentum_t predict_momentum(logic [143:0] d);
		momentum_t m;
		longint cx, cy, e, vx, vy, vz, dz, sx, sy, r;
		cx = longint'($signed(d[23:0]));
		cy = longint'($signed(d[47:24]));
		e  = longint'(d[64:48]);
		vx = longint'($signed(d[88:65]));
		vy = longint'($signed(d[112:89]));
		vz = longint'($signed(d[136:113]));
		dz = vz - (longint'(front_z) + 4224 + (43 * e + 20) / 40);
		m = '0;
		m.me = e[16:0];
		if (dz == 0) begin
			m.fault = 1'b1;
		end else begin
			sx = slope(vx - cx, dz);
			sy = slope(vy - cy, dz);
			r = isqrt((64'd1 << 40) + sx * sx + sy * sy);
			m.mz = 17'((e * 1048576) / r);
			m.mx = 18'((e * sx) / r);
			m.my = 18'((e * sy) / r);
		end
		return m;
	endfunction

	function automatic logic [143:0] pack_item(logic [23:0] cx, logic [23:0] cy,
			logic [16:0] e, logic [23:0] vx, logic [23:0] vy, logic [23:0] vz);
		return {7'd0, vz, vy, vx, e, cy, cx};
	endfunction

	task automatic write_front(logic [22:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= RegFront; pwdata <= {9'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		front_z = v;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (prdata !== {9'd0, v}) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Register read mismatch: expected %h, got %h", {9'd0, v}, prdata);
		end
	endtask

	// One transfer on the input side, with a random gap once a burst is spent.
	task automatic send_item(logic [143:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_momenta.push_back(predict_momentum(d));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_momenta.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_free) m_axis_tready <= 1'b1;
		else m_axis_tready <= (($urandom & 7) != 0) || ((($time / 1000) % 3) == 0);
	end

	always @(posedge clk) begin
		momentum_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.mx    = m_axis_tdata[17:0];
			got.my    = m_axis_tdata[35:18];
			got.mz    = m_axis_tdata[52:36];
			got.me    = m_axis_tdata[69:53];
			got.fault = m_axis_tdata[70];
			if (pending_momenta.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %h", m_axis_tdata);
			end else begin
				want = pending_momenta.pop_front();
				if (got !== want || m_axis_tdata[79:71] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected px=%0d py=%0d pz=%0d e=%0d f=%0b,",
							" got px=%0d py=%0d pz=%0d e=%0d f=%0b"},
							want.mx, want.my, want.mz, want.me, want.fault,
							got.mx, got.my, got.mz, got.me, got.fault);
				end
			end
		end
	end

	task automatic test_extremes();
		logic [16:0] e;
		send_item(pack_item(24'h7FFFFF, 24'h800000, 17'h1FFFF, 24'h800000, 24'h7FFFFF, 24'h800000));
		send_item(pack_item(24'h800000, 24'h7FFFFF, 17'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
		send_item(pack_item(24'hFFFFFF, 24'hFFFFFF, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
		send_item(pack_item('0, '0, 17'd1024, '0, '0, '0));
		// Vertex on the axis straight in front of the shower.
		send_item(pack_item(24'd100, 24'd100, 17'd5000, 24'd100, 24'd100, 24'd1000));
		// Almost parallel to the calorimeter face, so both slopes saturate.
		send_item(pack_item(24'h7FFFFF, 24'h7FFFFF, 17'd0, 24'h800000, 24'h800000, 24'd4223));
		send_item(pack_item(24'h800000, 24'h800000, 17'd0, 24'h7FFFFF, 24'h7FFFFF, 24'd4225));
		// The vertex lies exactly at shower depth.
		e = 17'd2000;
		send_item(pack_item(24'd5, 24'd7, e, 24'd9, 24'd11,
			24'(front_z + 4224 + (43 * 2000 + 20) / 40)));
		send_item(pack_item(24'h123456, 24'h654321, 17'd0, 24'h0, 24'h0, 24'(front_z + 4224)));
		send_item(pack_item(24'h7FFFFF, 24'h0, 17'h1FFFF, 24'h0, 24'h7FFFFF,
			24'(front_z + 4224 + (43 * 131071 + 20) / 40)));
	endtask

	task automatic test_random(int n);
		logic [16:0] e;
		logic [23:0] vz;
		for (int i = 0; i < n; i++) begin
			e = (($urandom & 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 60000));
			case ($urandom_range(0, 5))
				0: vz = 24'(front_z + 4224 + (43 * e + 20) / 40);
				1: vz = 24'(front_z + 4224 + (43 * e + 20) / 40 + $urandom_range(0, 8) - 4);
				2: vz = 24'($urandom);
				default: vz = 24'(front_z + 4224 + (43 * e + 20) / 40 - $urandom_range(1, 400000));
			endcase
			if ($urandom & 1)
				send_item(pack_item(24'($urandom), 24'($urandom), e, 24'($urandom),
					24'($urandom), vz));
			else
				send_item(pack_item(24'($signed(16'($urandom))), 24'($signed(16'($urandom))), e,
					24'($signed(16'($urandom))), 24'($signed(16'($urandom))), vz));
		end
	endtask

	task automatic test_front_settings();
		logic [22:0] fronts[4] = '{23'h7FFFFF, 23'd0, 23'd300000, 23'($urandom)};
		foreach (fronts[k]) begin
			write_front(fronts[k]);
			stall_free = (k == 2);
			test_extremes();
			test_random(460);
			wait_drained();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_random(100);
		wait_drained();
		test_front_settings();
		if (mismatches == 0 && pending_momenta.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
